/* design/vat_pkg.sv */
// Shared types, constants and lane control decode for the vertex transform core.
`timescale 1ns / 1ps
package vat_pkg;

  localparam int COORD_W    = 32;
  localparam int TRIG_W     = 16;
  localparam int FAC_A_W    = 32;
  localparam int FAC_B_W    = TRIG_W + 1;
  localparam int PROD_A_W   = COORD_W + FAC_A_W;
  localparam int PROD_B_W   = COORD_W + FAC_B_W;
  localparam int SUM_W      = PROD_A_W + 2;
  localparam int MODE_W     = 3;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_W      = 32;
  localparam int NUM_LANES  = 3;
  localparam int LANE_IDX_W = 2;
  localparam int VTX_W      = NUM_LANES * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LANE_IDX_W-1:0]     lane_idx_t;
  typedef logic [MODE_W-1:0]         mode_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // modes
  localparam mode_t MODE_SCALE  = 3'd0;
  localparam mode_t MODE_MOVE_X = 3'd1;
  localparam mode_t MODE_MOVE_Y = 3'd2;
  localparam mode_t MODE_MOVE_Z = 3'd3;
  localparam mode_t MODE_ROT_X  = 3'd4;
  localparam mode_t MODE_ROT_Y  = 3'd5;
  localparam mode_t MODE_ROT_Z  = 3'd6;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MOVE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COS   = 3'd4;

  localparam lane_idx_t LANE_X = 2'd0;
  localparam lane_idx_t LANE_Y = 2'd1;
  localparam lane_idx_t LANE_Z = 2'd2;

  // multiplier A factor
  localparam logic [1:0] FA_ONE   = 2'd0;
  localparam logic [1:0] FA_SCALE = 2'd1;
  localparam logic [1:0] FA_COS   = 2'd2;
  // multiplier B factor
  localparam logic [1:0] FB_ZERO  = 2'd0;
  localparam logic [1:0] FB_SIN   = 2'd1;
  localparam logic [1:0] FB_NSIN  = 2'd2;
  // rounding shift
  localparam logic [1:0] SH_NONE  = 2'd0;
  localparam logic [1:0] SH_COORD = 2'd1;
  localparam logic [1:0] SH_TRIG  = 2'd2;

  typedef struct packed {
    logic [1:0] fa;
    logic [1:0] fb;
    lane_idx_t  b_src;
    logic       add_off;
    logic [1:0] sh;
  } lane_ctrl_t;

  // Lane result = round((own * A + other * B + offset) >> shift)
  function automatic lane_ctrl_t lane_ctrl(input mode_t mode, input lane_idx_t lane);
    lane_ctrl_t c;
    c.fa      = FA_ONE;
    c.fb      = FB_ZERO;
    c.b_src   = lane;
    c.add_off = 1'b0;
    c.sh      = SH_NONE;
    case (mode)
      MODE_SCALE: begin
        c.fa = FA_SCALE;
        c.sh = SH_COORD;
      end
      MODE_MOVE_X: c.add_off = (lane == LANE_X);
      MODE_MOVE_Y: c.add_off = (lane == LANE_Y);
      MODE_MOVE_Z: c.add_off = (lane == LANE_Z);
      MODE_ROT_X: begin
        if (lane == LANE_Y) begin
          c.fa = FA_COS; c.fb = FB_NSIN; c.b_src = LANE_Z; c.sh = SH_TRIG;
        end else if (lane == LANE_Z) begin
          c.fa = FA_COS; c.fb = FB_SIN; c.b_src = LANE_Y; c.sh = SH_TRIG;
        end
      end
      MODE_ROT_Y: begin
        if (lane == LANE_X) begin
          c.fa = FA_COS; c.fb = FB_SIN; c.b_src = LANE_Z; c.sh = SH_TRIG;
        end else if (lane == LANE_Z) begin
          c.fa = FA_COS; c.fb = FB_NSIN; c.b_src = LANE_X; c.sh = SH_TRIG;
        end
      end
      MODE_ROT_Z: begin
        if (lane == LANE_X) begin
          c.fa = FA_COS; c.fb = FB_NSIN; c.b_src = LANE_Y; c.sh = SH_TRIG;
        end else if (lane == LANE_Y) begin
          c.fa = FA_COS; c.fb = FB_SIN; c.b_src = LANE_X; c.sh = SH_TRIG;
        end
      end
      default: ;
    endcase
    return c;
  endfunction

endpackage

/* design/vat_lane.sv */
// One coordinate lane: two multipliers, registered, then sum, round and clamp.
`timescale 1ns / 1ps
module vat_lane #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic                                      clk,
  input  logic                                      load,
  input  vat_pkg::lane_ctrl_t                       ctrl,
  input  vat_pkg::coord_t                           coord_a,
  input  vat_pkg::coord_t                           coord_b,
  input  logic signed [vat_pkg::FAC_A_W-1:0]        scale_factor,
  input  vat_pkg::coord_t                           move_offset,
  input  logic signed [vat_pkg::TRIG_W-1:0]         sine,
  input  logic signed [vat_pkg::TRIG_W-1:0]         cosine,
  output vat_pkg::coord_t                           res,
  output logic                                      sat
);
  import vat_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF_COORD = SUM_W'(1) << (COORD_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] HALF_TRIG  = SUM_W'(1) << (TRIG_FRAC_BITS - 1);

  logic signed [FAC_A_W-1:0]  fac_a;
  logic signed [FAC_B_W-1:0]  fac_b;
  logic signed [FAC_B_W-1:0]  sine_x;
  logic signed [PROD_A_W-1:0] prod_a_nxt, prod_a_r;
  logic signed [PROD_B_W-1:0] prod_b_nxt, prod_b_r;
  coord_t                     off_nxt, off_r;
  logic [1:0]                 sh_r;
  logic signed [SUM_W-1:0]    half;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    shifted;
  logic                       fits;

  assign sine_x = {sine[TRIG_W-1], sine};

  always_comb begin
    case (ctrl.fa)
      FA_SCALE: fac_a = scale_factor;
      FA_COS:   fac_a = {{(FAC_A_W-TRIG_W){cosine[TRIG_W-1]}}, cosine};
      default:  fac_a = FAC_A_W'(1);
    endcase
    case (ctrl.fb)
      FB_SIN:  fac_b = sine_x;
      FB_NSIN: fac_b = -sine_x;
      default: fac_b = '0;
    endcase
  end

  assign prod_a_nxt = coord_a * fac_a;
  assign prod_b_nxt = coord_b * fac_b;
  assign off_nxt    = ctrl.add_off ? move_offset : '0;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      off_r    <= off_nxt;
      sh_r     <= ctrl.sh;
    end
  end

  always_comb begin
    case (sh_r)
      SH_COORD: half = HALF_COORD;
      SH_TRIG:  half = HALF_TRIG;
      default:  half = '0;
    endcase
    sum = SUM_W'(prod_a_r) + SUM_W'(prod_b_r) + SUM_W'(off_r) + half;
    case (sh_r)
      SH_COORD: shifted = sum >>> COORD_FRAC_BITS;
      SH_TRIG:  shifted = sum >>> TRIG_FRAC_BITS;
      default:  shifted = sum;
    endcase
    fits = (&shifted[SUM_W-1:COORD_W-1]) || !(|shifted[SUM_W-1:COORD_W-1]);
    if (fits) begin
      res = shifted[COORD_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res = COORD_MIN;
    end else begin
      res = COORD_MAX;
    end
    sat = !fits;
  end

endmodule

/* design/vat_merge.sv */
// Output stage: merges lane results into one vertex transfer and holds it until taken.
`timescale 1ns / 1ps
module vat_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_last,
  input  vat_pkg::coord_t              lane_res [vat_pkg::NUM_LANES],
  input  logic [vat_pkg::NUM_LANES-1:0] lane_sat,
  output logic                         advance,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [vat_pkg::VTX_W-1:0]    out_tdata,
  output logic                         out_tlast,
  output logic                         out_tuser
);
  import vat_pkg::*;

  logic             valid_r;
  logic [VTX_W-1:0] data_r;
  logic             last_r;
  logic             sat_r;

  assign advance = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      data_r <= {lane_res[2], lane_res[1], lane_res[0]};
      last_r <= in_last;
      sat_r  <= |lane_sat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = sat_r;

endmodule

/* design/vertex_affine_transform_core.sv */
// Input transfers pass the multiply stage, then the output register, to reach out_tvalid.
// One vertex per cycle when not stalled; three coordinate lanes each hold one 32x32 and one
// 32x17 multiplier, and the merge stage registers the combined vertex and saturation flag.
// Reset (synchronous, rst_n low) empties the pipeline and restores the registers to
// mode scale, scale 1.0, offset 0, sine 0, cosine 1.0.
`timescale 1ns / 1ps
module vertex_affine_transform_core #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int TRIG_FRAC_BITS  = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [vat_pkg::VTX_W-1:0]       in_tdata,   // coord_x, coord_y, coord_z
  input  logic                            in_tlast,   // last_vertex
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vat_pkg::VTX_W-1:0]       out_tdata,  // out_x, out_y, out_z
  output logic                            out_tlast,  // out_last
  output logic                            out_tuser,  // saturated
  input  logic                            cfg_wr_en,
  input  logic [vat_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  logic [vat_pkg::CFG_W-1:0]       cfg_wdata
);
  import vat_pkg::*;

  mode_t                     mode_r;
  logic signed [FAC_A_W-1:0] scale_r;
  coord_t                    move_r;
  logic signed [TRIG_W-1:0]  sin_r;
  logic signed [TRIG_W-1:0]  cos_r;

  logic                      v1_r;
  logic                      last1_r;
  logic                      advance;
  logic                      load;
  coord_t                    coord [NUM_LANES];
  coord_t                    lane_res [NUM_LANES];
  logic [NUM_LANES-1:0]      lane_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SCALE;
      scale_r <= FAC_A_W'(1) << COORD_FRAC_BITS;
      move_r  <= '0;
      sin_r   <= '0;
      cos_r   <= TRIG_W'(1 << TRIG_FRAC_BITS);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MODE:  mode_r  <= cfg_wdata[MODE_W-1:0];
        REG_SCALE: scale_r <= cfg_wdata[FAC_A_W-1:0];
        REG_MOVE:  move_r  <= cfg_wdata[COORD_W-1:0];
        REG_SIN:   sin_r   <= cfg_wdata[TRIG_W-1:0];
        REG_COS:   cos_r   <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !v1_r || advance;
  assign load      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_tready) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last1_r <= in_tlast;
    end
  end

  genvar i;
  generate
    for (i = 0; i < NUM_LANES; i++) begin : g_lane
      lane_ctrl_t ctrl;
      assign coord[i] = in_tdata[i*COORD_W +: COORD_W];
      assign ctrl     = lane_ctrl(mode_r, LANE_IDX_W'(i));

      vat_lane #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
      ) u_lane (
        .clk         (clk),
        .load        (load),
        .ctrl        (ctrl),
        .coord_a     (coord[i]),
        .coord_b     (coord[ctrl.b_src]),
        .scale_factor(scale_r),
        .move_offset (move_r),
        .sine        (sin_r),
        .cosine      (cos_r),
        .res         (lane_res[i]),
        .sat         (lane_sat[i])
      );
    end
  endgenerate

  vat_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_last   (last1_r),
    .lane_res  (lane_res),
    .lane_sat  (lane_sat),
    .advance   (advance),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("multiply stage empty but input not ready");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !in_tready) |=> v1_r)
    else $error("stalled item dropped from multiply stage");

  a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && (!out_tvalid || out_tready)) |=> out_tvalid)
    else $error("item in multiply stage did not move to output");

endmodule
